// ===== hdl/jpsc_pkg.sv =====
package jpsc_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int ANGLE_W    = 9;
    localparam int GAIN_W     = 9;
    localparam int SPEED_W    = 8;
    localparam int ERR_W      = 10;
    localparam int DELTA_W    = ERR_W + 1;
    // Signed product of a sample and an angle span.
    localparam int PROD_W     = SAMPLE_W + ANGLE_W + 2;
    localparam int MAG_W      = PROD_W - 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [SPEED_W-1:0]  NULL_SPEED        = 8'd90;
    localparam logic [SAMPLE_W-1:0] SAMPLE_FULL_SCALE = 10'd1023;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_AT_MIN  = 3'd0,
        REG_ANGLE_AT_MAX  = 3'd1,
        REG_JOINT_LOW     = 3'd2,
        REG_JOINT_HIGH    = 3'd3,
        REG_PROP_GAIN     = 3'd4,
        REG_DERIV_GAIN    = 3'd5,
        REG_SPEED_BOUND_A = 3'd6,
        REG_SPEED_BOUND_B = 3'd7
    } cfg_reg_t;

endpackage

// ===== hdl/jpsc_div1023.sv =====
module jpsc_div1023 (
    input  logic signed [jpsc_pkg::PROD_W-1:0]  dividend,
    output logic        [jpsc_pkg::ANGLE_W-1:0] quot_mag,
    output logic                                quot_neg
);
    import jpsc_pkg::*;

    logic signed [PROD_W-1:0] neg_dividend;
    logic [MAG_W-1:0]         mag;
    logic [SAMPLE_W-1:0]      q_est;
    logic [SAMPLE_W:0]        remainder;
    logic [SAMPLE_W-1:0]      q_full;

    // The quotient truncates toward zero, so divide the magnitude and
    // put the sign back afterwards.
    assign quot_neg     = dividend[PROD_W-1];
    assign neg_dividend = -dividend;
    assign mag          = quot_neg ? neg_dividend[MAG_W-1:0] : dividend[MAG_W-1:0];

    // Dividing by 1024 underestimates; the remainder against 1023 is then
    // the low ten bits plus the estimate, which stays below twice 1023.
    assign q_est     = mag[MAG_W-1:MAG_W-SAMPLE_W];
    assign remainder = {1'b0, mag[SAMPLE_W-1:0]} + {1'b0, q_est};
    assign q_full    = (remainder >= {1'b0, SAMPLE_FULL_SCALE}) ? q_est + 10'd1 : q_est;
    assign quot_mag  = q_full[ANGLE_W-1:0];

endmodule

// ===== hdl/joint_pd_speed_controller.sv =====
// Joint PD speed controller. Each input beat carries a potentiometer sample and a
// target angle; each output beat carries the clamped speed command and an accepted
// flag. The datapath is a six-register pipeline (input, span product, divide by
// 1023, error and error change, gain products, clamped result), and a new beat can
// be taken in every cycle while the output is not stalled. The stored previous error
// is updated in the error stage, so each beat sees the error of the last accepted
// beat before it without any wait. A stalled output holds the pipeline; empty stages
// still fill up while it waits. Configuration
// registers should be written only while no beat is in flight.
module joint_pd_speed_controller (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [jpsc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [jpsc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [jpsc_pkg::SAMPLE_W-1:0]          pot_sample,
    input  logic [jpsc_pkg::ANGLE_W-1:0]           target_angle,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [jpsc_pkg::SPEED_W-1:0]           speed_command,
    output logic                                   accepted
);
    import jpsc_pkg::*;

    // Configuration registers.
    logic [ANGLE_W-1:0]       angle_min_reg;
    logic [ANGLE_W-1:0]       angle_max_reg;
    logic [ANGLE_W-1:0]       joint_low_reg;
    logic [ANGLE_W-1:0]       joint_high_reg;
    logic signed [GAIN_W-1:0] prop_gain_reg;
    logic signed [GAIN_W-1:0] deriv_gain_reg;
    logic [SPEED_W-1:0]       bound_a_reg;
    logic [SPEED_W-1:0]       bound_b_reg;

    logic signed [ERR_W-1:0]  last_error_reg;

    // Pipeline valids and loads.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic load1, load2, load3, load4, load5, load_o;

    // Stage 1: input register.
    logic [SAMPLE_W-1:0]      s1_sample_reg;
    logic [ANGLE_W-1:0]       s1_target_reg;
    // Stage 2: span product.
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic [ANGLE_W-1:0]       s2_target_reg;
    logic                     s2_inlim_reg;
    // Stage 3: quotient.
    logic [ANGLE_W-1:0]       s3_quot_reg;
    logic                     s3_neg_reg;
    logic [ANGLE_W-1:0]       s3_target_reg;
    logic                     s3_inlim_reg;
    // Stage 4: error and error change.
    logic signed [ERR_W-1:0]   s4_err_reg;
    logic signed [DELTA_W-1:0] s4_delta_reg;
    logic                      s4_inlim_reg;
    // Stage 5: gain products.
    logic signed [GAIN_W+ERR_W-1:0]   s5_pterm_reg;
    logic signed [GAIN_W+DELTA_W-1:0] s5_dterm_reg;
    logic                             s5_inlim_reg;
    // Output register.
    logic [SPEED_W-1:0]       speed_reg;
    logic                     accepted_reg;

    // Combinational next values.
    logic signed [SAMPLE_W-1:0] span;
    logic signed [PROD_W-1:0]   s2_prod_next;
    logic                       s2_inlim_next;
    logic [ANGLE_W-1:0]         s3_quot_next;
    logic                       s3_neg_next;
    logic signed [DELTA_W-1:0]  quot_signed;
    logic signed [DELTA_W-1:0]  angle;
    logic signed [DELTA_W-1:0]  err_wide;
    logic signed [ERR_W-1:0]    s4_err_next;
    logic signed [DELTA_W-1:0]  s4_delta_next;
    logic signed [GAIN_W+ERR_W-1:0]   s5_pterm_next;
    logic signed [GAIN_W+DELTA_W-1:0] s5_dterm_next;
    logic signed [PROD_W-1:0]   speed_sum;
    logic signed [PROD_W-1:0]   bmin_ext;
    logic signed [PROD_W-1:0]   bmax_ext;
    logic [SPEED_W-1:0]         bmin;
    logic [SPEED_W-1:0]         bmax;
    logic [SPEED_W-1:0]         speed_next;

    // A stage loads when it is empty or the stage after it loads too.
    assign load_o   = !vo_reg || out_ready;
    assign load5    = !v5_reg || load_o;
    assign load4    = !v4_reg || load5;
    assign load3    = !v3_reg || load4;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign in_ready = load1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_min_reg  <= 9'd0;
            angle_max_reg  <= 9'd360;
            joint_low_reg  <= 9'd0;
            joint_high_reg <= 9'd360;
            prop_gain_reg  <= 9'sd1;
            deriv_gain_reg <= 9'sd0;
            bound_a_reg    <= 8'd0;
            bound_b_reg    <= 8'd180;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ANGLE_AT_MIN:  angle_min_reg  <= cfg_data;
                REG_ANGLE_AT_MAX:  angle_max_reg  <= cfg_data;
                REG_JOINT_LOW:     joint_low_reg  <= cfg_data;
                REG_JOINT_HIGH:    joint_high_reg <= cfg_data;
                REG_PROP_GAIN:     prop_gain_reg  <= $signed(cfg_data);
                REG_DERIV_GAIN:    deriv_gain_reg <= $signed(cfg_data);
                REG_SPEED_BOUND_A: bound_a_reg    <= cfg_data[SPEED_W-1:0];
                REG_SPEED_BOUND_B: bound_b_reg    <= cfg_data[SPEED_W-1:0];
            endcase
        end
    end

    // Stage 1 to 2: span product and limit check.
    assign span          = $signed({1'b0, angle_max_reg}) - $signed({1'b0, angle_min_reg});
    assign s2_prod_next  = $signed({1'b0, s1_sample_reg}) * span;
    assign s2_inlim_next = (s1_target_reg > joint_low_reg) && (s1_target_reg < joint_high_reg);

    // Stage 2 to 3: divide by full scale.
    jpsc_div1023 u_div (
        .dividend (s2_prod_reg),
        .quot_mag (s3_quot_next),
        .quot_neg (s3_neg_next)
    );

    // Stage 3 to 4: angle, error and error change against the stored error.
    assign quot_signed   = s3_neg_reg ? -$signed({2'b00, s3_quot_reg})
                                      :  $signed({2'b00, s3_quot_reg});
    assign angle         = $signed({2'b00, angle_min_reg}) + quot_signed;
    assign err_wide      = angle - $signed({2'b00, s3_target_reg});
    assign s4_err_next   = err_wide[ERR_W-1:0];
    assign s4_delta_next = $signed({s4_err_next[ERR_W-1], s4_err_next})
                         - $signed({last_error_reg[ERR_W-1], last_error_reg});

    // Stage 4 to 5: gain products.
    assign s5_pterm_next = prop_gain_reg * s4_err_reg;
    assign s5_dterm_next = deriv_gain_reg * s4_delta_reg;

    // Stage 5 to output: sum and clamp, bounds taken in either order.
    assign bmin      = (bound_a_reg > bound_b_reg) ? bound_b_reg : bound_a_reg;
    assign bmax      = (bound_a_reg > bound_b_reg) ? bound_a_reg : bound_b_reg;
    assign bmin_ext  = $signed({{(PROD_W-SPEED_W){1'b0}}, bmin});
    assign bmax_ext  = $signed({{(PROD_W-SPEED_W){1'b0}}, bmax});
    assign speed_sum = $signed({{(PROD_W-SPEED_W){1'b0}}, NULL_SPEED})
                     + PROD_W'(s5_pterm_reg) + PROD_W'(s5_dterm_reg);

    always_comb
    begin
        if (!s5_inlim_reg)
            speed_next = NULL_SPEED;
        else if (speed_sum > bmax_ext)
            speed_next = bmax;
        else if (speed_sum < bmin_ext)
            speed_next = bmin;
        else
            speed_next = speed_sum[SPEED_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
            vo_reg         <= 1'b0;
            last_error_reg <= '0;
        end
        else
        begin
            if (load1)
                v1_reg <= in_valid;
            if (load2)
                v2_reg <= v1_reg;
            if (load3)
                v3_reg <= v2_reg;
            if (load4)
                v4_reg <= v3_reg;
            if (load5)
                v5_reg <= v4_reg;
            if (load_o)
                vo_reg <= v5_reg;
            // Only a driven beat replaces the stored error.
            if (load4 && v3_reg && s3_inlim_reg)
                last_error_reg <= s4_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_sample_reg <= pot_sample;
            s1_target_reg <= target_angle;
        end
        if (load2)
        begin
            s2_prod_reg   <= s2_prod_next;
            s2_target_reg <= s1_target_reg;
            s2_inlim_reg  <= s2_inlim_next;
        end
        if (load3)
        begin
            s3_quot_reg   <= s3_quot_next;
            s3_neg_reg    <= s3_neg_next;
            s3_target_reg <= s2_target_reg;
            s3_inlim_reg  <= s2_inlim_reg;
        end
        if (load4)
        begin
            s4_err_reg   <= s4_err_next;
            s4_delta_reg <= s4_delta_next;
            s4_inlim_reg <= s3_inlim_reg;
        end
        if (load5)
        begin
            s5_pterm_reg <= s5_pterm_next;
            s5_dterm_reg <= s5_dterm_next;
            s5_inlim_reg <= s4_inlim_reg;
        end
        if (load_o)
        begin
            speed_reg    <= speed_next;
            accepted_reg <= s5_inlim_reg;
        end
    end

    assign out_valid     = vo_reg;
    assign speed_command = speed_reg;
    assign accepted      = accepted_reg;

endmodule

// ===== hdl/jpsc_checker.sv =====
module jpsc_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic [jpsc_pkg::SPEED_W-1:0]           speed_command,
    input  logic                                   accepted
);
    import jpsc_pkg::*;

    localparam logic [2:0] PIPE_DEPTH = 3'd6;

    logic       in_beat;
    logic       out_beat;
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    assign in_beat       = in_valid && in_ready;
    assign out_beat      = out_valid && out_ready;
    assign inflight_next = inflight_reg + 3'(in_beat) - 3'(out_beat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 3'd0;
        else
            inflight_reg <= inflight_next;
    end

    // Every result beat must belong to an input beat already taken.
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("result offered with no input beat in flight");

    // The pipeline cannot hold more beats than it has registers.
    a_inflight_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= PIPE_DEPTH)
        else $error("more beats in flight than pipeline registers");

    // A refused target always yields the stop command.
    a_refused_is_null: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> speed_command == NULL_SPEED)
        else $error("refused target without null speed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(speed_command) && $stable(accepted))
        else $error("stalled result beat changed");

endmodule

bind joint_pd_speed_controller jpsc_checker u_jpsc_checker (.*);
